// File: rtl/wpps_pkg.sv
// ----------------------------------------------------------------------------
// W-projection phase screen package
// Shared types, register indexes, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package wpps_pkg;

    // Result selection carried down the pipeline with each pixel
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE,
        KIND_CALC
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SCREEN_SIZE,
        REG_INNER_SIZE,
        REG_W_PLANES,
        REG_W_PIXEL,
        REG_W_SCALE,
        REG_SAMPLING_L,
        REG_SAMPLING_M
    } t_reg_idx;

    // Quadrant of the phase angle
    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_ctl;

    // Side data that travels through the series stages
    typedef struct packed {
        t_ctl               ctl;
        t_quad              quad;
        logic [31:0]        x2;
        logic signed [33:0] s;
        logic signed [33:0] c;
    } t_carry;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 72;
    localparam int TAYLOR_TERMS = 7;

    localparam logic [32:0]        HALF_PI_Q32 = 33'h1_921F_B544;
    localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;
    localparam logic signed [33:0] ONE_Q30_S   = 34'sh0_4000_0000;
    localparam logic [15:0]        ONE_Q14     = 16'd16384;

    // Divisor of the k-th sine term: (2k)(2k+1)
    function automatic int sin_div(input int k);
        return (2 * k) * (2 * k + 1);
    endfunction

    // Divisor of the k-th cosine term: (2k-1)(2k)
    function automatic int cos_div(input int k);
        return (2 * k - 1) * (2 * k);
    endfunction

    // Clamp a Q.30 value to [0, 1] and round it to Q1.14
    function automatic logic [14:0] to_q14(input logic signed [33:0] v);
        logic [30:0] sum;
        sum = v[30:0] + 31'h0000_8000;
        if (v < 0) begin
            return '0;
        end else if (v > ONE_Q30_S) begin
            return 15'd16384;
        end
        return sum[30:16];
    endfunction

endpackage

// File: rtl/w_projection_phase_screen.sv
// ----------------------------------------------------------------------------
// W-projection phase screen
// Streams screen pixels in and returns the complex w-term value of each.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) takes one pixel per transaction: column, row.
//   Master channel (m_axis_*) returns one value per pixel, in order:
//   real_part and imag_part, Q1.14.
//   Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata);
//   write registers only while no pixel is in flight.
// Throughput: one pixel per cycle while the output is taken (see Stall).
// Structure: the 72-step restoring divider (phase scaling by w_scale)
//   and the 32-step square root are the longest sections; the Taylor
//   series adds 21 stages.
// Reset: empties the pipeline and restores the register defaults
//   (64, 64, 1, 0, 65536, 0, 0).
// Stall: when the output holds a value that is not taken, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module w_projection_phase_screen
    import wpps_pkg::*;
#(
    parameter int ANGLE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [11:0] column, [23:12] row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [15:0] real_part, [31:16] imag_part
);

    localparam logic [31:0] ANGLE_MASK =
        ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] r_screen_size, r_inner_size;
    logic [10:0] r_w_planes;
    logic [11:0] r_w_pixel;
    logic [31:0] r_w_scale, r_samp_l, r_samp_m;
    logic [23:0] r_w2;
    logic [31:0] r_ws;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_size <= 13'd64;
            r_inner_size  <= 13'd64;
            r_w_planes    <= 11'd1;
            r_w_pixel     <= 12'd0;
            r_w_scale     <= 32'd65536;
            r_samp_l      <= 32'd0;
            r_samp_m      <= 32'd0;
            r_w2          <= 24'd0;
            r_ws          <= 32'd65536;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_SCREEN_SIZE: r_screen_size <= i_cfg_wdata[12:0];
                    REG_INNER_SIZE:  r_inner_size  <= i_cfg_wdata[12:0];
                    REG_W_PLANES:    r_w_planes    <= i_cfg_wdata[10:0];
                    REG_W_PIXEL:     r_w_pixel     <= i_cfg_wdata[11:0];
                    REG_W_SCALE:     r_w_scale     <= i_cfg_wdata;
                    REG_SAMPLING_L:  r_samp_l      <= i_cfg_wdata;
                    REG_SAMPLING_M:  r_samp_m      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // Derived values, refreshed every cycle
            r_w2 <= r_w_pixel * r_w_pixel;
            r_ws <= (r_w_scale == 32'd0) ? 32'd1 : r_w_scale;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: hold everything while the output waits
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        w_adv;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ------------------------------------------------------------------
    // Stage 1: center the pixel, test screen and window
    // ------------------------------------------------------------------
    logic [11:0] w_col, w_row, w_half_s, w_half_i;
    logic [13:0] w_ix, w_iy, w_ix_abs, w_iy_abs, w_neg_half, w_pos_half;
    logic        w_on_screen, w_in_win;
    t_kind       n_kind1;

    assign w_col      = s_axis_tdata[11:0];
    assign w_row      = s_axis_tdata[23:12];
    assign w_half_s   = r_screen_size[12:1];
    assign w_half_i   = r_inner_size[12:1];
    assign w_ix       = {2'b00, w_col} - {2'b00, w_half_s};
    assign w_iy       = {2'b00, w_row} - {2'b00, w_half_s};
    assign w_ix_abs   = w_ix[13] ? (14'd0 - w_ix) : w_ix;
    assign w_iy_abs   = w_iy[13] ? (14'd0 - w_iy) : w_iy;
    assign w_pos_half = {2'b00, w_half_i};
    assign w_neg_half = 14'd0 - w_pos_half;

    always_comb begin
        w_on_screen = ({1'b0, w_col} < r_screen_size) && ({1'b0, w_row} < r_screen_size);
        w_in_win    = ($signed(w_ix) >= $signed(w_neg_half)) &&
                      ($signed(w_ix) <  $signed(w_pos_half)) &&
                      ($signed(w_iy) >= $signed(w_neg_half)) &&
                      ($signed(w_iy) <  $signed(w_pos_half));
        if (!w_on_screen) begin
            n_kind1 = KIND_ZERO;
        end else if (r_w_planes <= 11'd1) begin
            n_kind1 = KIND_ONE;
        end else if (!w_in_win) begin
            n_kind1 = KIND_ZERO;
        end else begin
            n_kind1 = KIND_CALC;
        end
    end

    t_ctl        r_c1, r_c2, r_c3;
    logic [11:0] r_ax1, r_ay1;
    logic [43:0] r_a2, r_b2;
    logic [63:0] r_asq3, r_bsq3;
    logic        w_inside3;

    assign w_inside3 = (r_a2[43:32] == 12'd0) && (r_b2[43:32] == 12'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (w_adv) begin
            r_c1 <= '{valid: s_axis_tvalid, kind: n_kind1};
            r_c2 <= r_c1;
            r_c3 <= '{valid: r_c2.valid,
                      kind: ((r_c2.kind == KIND_CALC) && !w_inside3) ? KIND_ZERO : r_c2.kind};
        end
    end

    // Stages 2 and 3: direction cosines, then their squares
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ax1  <= w_ix_abs[11:0];
            r_ay1  <= w_iy_abs[11:0];
            r_a2   <= r_samp_l * r_ax1;
            r_b2   <= r_samp_m * r_ay1;
            r_asq3 <= r_a2[31:0] * r_a2[31:0];
            r_bsq3 <= r_b2[31:0] * r_b2[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rsq, unit-circle test, radicand 1 - rsq
    // ------------------------------------------------------------------
    t_ctl        r_sq_ctl  [SQRT_STEPS + 1];
    logic [63:0] r_sq_rad  [SQRT_STEPS + 1];
    logic [32:0] r_sq_rem  [SQRT_STEPS + 1];
    logic [31:0] r_sq_root [SQRT_STEPS + 1];
    logic [64:0] w_rsq;

    assign w_rsq = {1'b0, r_asq3} + {1'b0, r_bsq3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl[0] <= '0;
        end else if (w_adv) begin
            r_sq_ctl[0] <= '{valid: r_c3.valid,
                             kind: ((r_c3.kind == KIND_CALC) && w_rsq[64]) ? KIND_ZERO
                                                                        : r_c3.kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_rad[0]  <= 64'd0 - w_rsq[63:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [34:0] n_shift, n_trial, n_diff;
        logic        n_bit;

        always_comb begin
            n_shift = {r_sq_rem[j], r_sq_rad[j][63:62]};
            n_trial = {1'b0, r_sq_root[j], 2'b01};
            n_bit   = (n_shift >= n_trial);
            n_diff  = n_shift - n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctl[j + 1] <= '0;
            end else if (w_adv) begin
                r_sq_ctl[j + 1] <= r_sq_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rad[j + 1]  <= {r_sq_rad[j][61:0], 2'b00};
                r_sq_rem[j + 1]  <= n_bit ? n_diff[32:0] : n_shift[32:0];
                r_sq_root[j + 1] <= {r_sq_root[j][30:0], n_bit};
            end
        end
    end

    // ------------------------------------------------------------------
    // t = 1 - sqrt(1 - rsq) (zero radicand wraps to t = 0), then w^2 * t
    // ------------------------------------------------------------------
    t_ctl        r_t_ctl;
    logic [31:0] r_t;

    t_ctl        r_dv_ctl [DIV_STEPS + 1];
    logic [71:0] r_dv_num [DIV_STEPS + 1];
    logic [31:0] r_dv_rem [DIV_STEPS + 1];
    logic [31:0] r_dv_quo [DIV_STEPS + 1];
    logic [55:0] w_n;

    assign w_n = r_w2 * r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_ctl     <= '0;
            r_dv_ctl[0] <= '0;
        end else if (w_adv) begin
            r_t_ctl     <= r_sq_ctl[SQRT_STEPS];
            r_dv_ctl[0] <= r_t_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t         <= 32'd0 - r_sq_root[SQRT_STEPS];
            r_dv_num[0] <= {w_n, 16'h0000};
            r_dv_rem[0] <= '0;
            r_dv_quo[0] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divide by w_scale: one quotient bit per stage, low 32 kept
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [32:0] n_shift, n_diff;
        logic        n_bit;

        always_comb begin
            n_shift = {r_dv_rem[j], r_dv_num[j][71]};
            n_bit   = (n_shift >= {1'b0, r_ws});
            n_diff  = n_shift - {1'b0, r_ws};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[j + 1] <= '0;
            end else if (w_adv) begin
                r_dv_ctl[j + 1] <= r_dv_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_num[j + 1] <= {r_dv_num[j][70:0], 1'b0};
                r_dv_rem[j + 1] <= n_bit ? n_diff[31:0] : n_shift[31:0];
                r_dv_quo[j + 1] <= {r_dv_quo[j][30:0], n_bit};
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle: negate, truncate, split quadrant, scale to radians, square
    // ------------------------------------------------------------------
    logic [31:0] w_p;
    logic [62:0] w_xprod;
    t_ctl        r_x_ctl;
    t_quad       r_x_quad;
    logic [30:0] r_x;
    logic [61:0] w_xsq;

    assign w_p     = (32'd0 - r_dv_quo[DIV_STEPS]) & ANGLE_MASK;
    assign w_xprod = w_p[29:0] * HALF_PI_Q32;
    assign w_xsq   = r_x * r_x;

    t_carry      r_ty_cy [TAYLOR_TERMS + 1];
    logic [31:0] r_ty_ts [TAYLOR_TERMS + 1];
    logic [31:0] r_ty_tc [TAYLOR_TERMS + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_ctl        <= '0;
            r_ty_cy[0].ctl <= '0;
        end else if (w_adv) begin
            r_x_ctl    <= r_dv_ctl[DIV_STEPS];
            r_ty_cy[0] <= '{ctl: r_x_ctl, quad: r_x_quad, x2: w_xsq[61:30],
                            s: {3'b000, r_x}, c: {2'b00, ONE_Q30}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x_quad   <= t_quad'(w_p[31:30]);
            r_x        <= w_xprod[62:32];
            r_ty_ts[0] <= {1'b0, r_x};
            r_ty_tc[0] <= ONE_Q30;
        end
    end

    // ------------------------------------------------------------------
    // Taylor series: per term multiply by x^2, reciprocal divide, correct
    // ------------------------------------------------------------------
    for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
        localparam int          DIV_S = sin_div(k + 1);
        localparam int          DIV_C = cos_div(k + 1);
        localparam logic [7:0]  D_S   = 8'(DIV_S);
        localparam logic [7:0]  D_C   = 8'(DIV_C);
        localparam logic [31:0] RCP_S = 32'(64'h1_0000_0000 / 64'(DIV_S));
        localparam logic [31:0] RCP_C = 32'(64'h1_0000_0000 / 64'(DIV_C));

        t_carry      r_a_cy, r_b_cy;
        logic [31:0] r_a_vs, r_a_vc, r_b_vs, r_b_vc, r_b_qs, r_b_qc;
        logic [63:0] n_ps, n_pc, n_rs_p, n_rc_p;
        logic [39:0] n_ms, n_mc, n_rs, n_rc;
        logic [31:0] n_qs, n_qc;
        logic signed [33:0] n_s, n_c;

        always_comb begin
            n_ps   = r_ty_ts[k] * r_ty_cy[k].x2;
            n_pc   = r_ty_tc[k] * r_ty_cy[k].x2;
            n_rs_p = r_a_vs * RCP_S;
            n_rc_p = r_a_vc * RCP_C;
            n_ms   = r_b_qs * D_S;
            n_mc   = r_b_qc * D_C;
            n_rs   = {8'h00, r_b_vs} - n_ms;
            n_rc   = {8'h00, r_b_vc} - n_mc;
            n_qs   = r_b_qs + {31'd0, (n_rs >= {32'd0, D_S})};
            n_qc   = r_b_qc + {31'd0, (n_rc >= {32'd0, D_C})};
            if (k % 2 == 0) begin
                n_s = r_b_cy.s - $signed({2'b00, n_qs});
                n_c = r_b_cy.c - $signed({2'b00, n_qc});
            end else begin
                n_s = r_b_cy.s + $signed({2'b00, n_qs});
                n_c = r_b_cy.c + $signed({2'b00, n_qc});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_cy             <= '0;
                r_b_cy             <= '0;
                r_ty_cy[k + 1].ctl <= '0;
            end else if (w_adv) begin
                r_a_cy         <= r_ty_cy[k];
                r_b_cy         <= r_a_cy;
                r_ty_cy[k + 1] <= '{ctl: r_b_cy.ctl, quad: r_b_cy.quad, x2: r_b_cy.x2,
                                   s: n_s, c: n_c};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_a_vs         <= n_ps[61:30];
                r_a_vc         <= n_pc[61:30];
                r_b_vs         <= r_a_vs;
                r_b_vc         <= r_a_vc;
                r_b_qs         <= n_rs_p[63:32];
                r_b_qc         <= n_rc_p[63:32];
                r_ty_ts[k + 1] <= n_qs;
                r_ty_tc[k + 1] <= n_qc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: round, place in quadrant, select special cases
    // ------------------------------------------------------------------
    logic [15:0] w_cq, w_sq, n_re, n_im;
    t_carry      w_fin;

    assign w_fin = r_ty_cy[TAYLOR_TERMS];
    assign w_cq  = {1'b0, to_q14(w_fin.c)};
    assign w_sq  = {1'b0, to_q14(w_fin.s)};

    always_comb begin
        case (w_fin.ctl.kind)
            KIND_ONE: begin
                n_re = ONE_Q14;
                n_im = 16'd0;
            end
            KIND_CALC: begin
                case (w_fin.quad)
                    QUAD_I: begin
                        n_re = w_cq;
                        n_im = w_sq;
                    end
                    QUAD_II: begin
                        n_re = 16'd0 - w_sq;
                        n_im = w_cq;
                    end
                    QUAD_III: begin
                        n_re = 16'd0 - w_cq;
                        n_im = 16'd0 - w_sq;
                    end
                    default: begin
                        n_re = w_sq;
                        n_im = 16'd0 - w_cq;
                    end
                endcase
            end
            default: begin
                n_re = 16'd0;
                n_im = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fin.ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {n_im, n_re};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Come out of reset with the output empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Keep both parts within Q1.14 unit range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[15:0])  >= -16'sd16384) &&
            ($signed(m_axis_tdata[15:0])  <=  16'sd16384) &&
            ($signed(m_axis_tdata[31:16]) >= -16'sd16384) &&
            ($signed(m_axis_tdata[31:16]) <=  16'sd16384))
        else $error("output outside unit range");

    // Square root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_ctl[SQRT_STEPS].valid |->
            (r_sq_rem[SQRT_STEPS] <= {r_sq_root[SQRT_STEPS], 1'b0}))
        else $error("square root remainder out of bound");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_ctl[DIV_STEPS].valid |-> (r_dv_rem[DIV_STEPS] < r_ws))
        else $error("divider remainder not below divisor");

    // Hold the divider quotient and square root result while stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_dv_quo[DIV_STEPS]) && $stable(r_sq_root[SQRT_STEPS]))
        else $error("pipeline moved during a stall");

endmodule
